>>> hdl/ibst_pkg.sv
package ibst_pkg;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // position within a tree level; covers slot counts up to 65535
    localparam int POS_W  = 16;
    localparam int SLOT_W = 10;

    // work token handed from level to level
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [31:0]       key;
        logic [POS_W-1:0]  pos;
        logic              done;
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
    } t_token;

endpackage

>>> hdl/ibst_req_if.sv
interface ibst_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink (input valid, input operation, input key, output ready);
endinterface

>>> hdl/ibst_rsp_if.sv
interface ibst_rsp_if;
    logic       valid;
    logic       ready;
    logic [9:0] slot_index;
    logic [2:0] status;

    modport source (output valid, output slot_index, output status, input ready);
    modport sink (input valid, input slot_index, input status, output ready);
endinterface

>>> hdl/ibst_cell.sv
module ibst_cell #(
    parameter int SLOTS = 1024,
    parameter int LEVEL = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ibst_pkg::t_token i_tok,
    output ibst_pkg::t_token o_tok,
    output logic            o_clr_done
);
    localparam int BASE  = (1 << LEVEL) - 1;
    localparam int FULL  = 1 << LEVEL;
    localparam int DEPTH = ((SLOTS - BASE) < FULL) ? (SLOTS - BASE) : FULL;
    localparam int AW    = (DEPTH <= 1) ? 1 : $clog2(DEPTH);
    localparam logic [ibst_pkg::POS_W-1:0] BASE_V  = ibst_pkg::POS_W'(BASE);
    localparam logic [ibst_pkg::POS_W-1:0] DEPTH_V = ibst_pkg::POS_W'(DEPTH);
    localparam logic [AW:0] LAST_CLR = (AW+1)'(DEPTH - 1);

    // slots of this level
    logic [31:0] r_key_mem  [DEPTH];
    logic        r_used_mem [DEPTH];

    ibst_pkg::t_token r_tok, r_out, n_out;
    logic [31:0] r_rd_key;
    logic        r_rd_used;
    logic [AW:0] r_clr;
    logic        r_clr_busy;
    logic        wr_en;
    logic [ibst_pkg::POS_W-1:0] slot_num;
    logic        in_range, less;

    // occupancy sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            if (r_clr == LAST_CLR) begin
                r_clr_busy <= 1'b0;
            end
            r_clr <= r_clr + 1'b1;
        end
    end
    assign o_clr_done = !r_clr_busy;

    // memory read at token arrival, write at decision
    always_ff @(posedge i_clk) begin
        r_rd_key  <= r_key_mem[i_tok.pos[AW-1:0]];
        r_rd_used <= r_used_mem[i_tok.pos[AW-1:0]];
        if (r_clr_busy) begin
            r_used_mem[r_clr[AW-1:0]] <= 1'b0;
        end else if (wr_en) begin
            r_used_mem[r_tok.pos[AW-1:0]] <= 1'b1;
            r_key_mem[r_tok.pos[AW-1:0]]  <= r_tok.key;
        end
    end

    // token registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_out.valid <= n_out.valid;
        end
        r_tok.op     <= i_tok.op;
        r_tok.key    <= i_tok.key;
        r_tok.pos    <= i_tok.pos;
        r_tok.done   <= i_tok.done;
        r_tok.status <= i_tok.status;
        r_tok.slot   <= i_tok.slot;
        r_out.op     <= n_out.op;
        r_out.key    <= n_out.key;
        r_out.pos    <= n_out.pos;
        r_out.done   <= n_out.done;
        r_out.status <= n_out.status;
        r_out.slot   <= n_out.slot;
    end

    // compare against the stored slot, then stop or step to a child
    always_comb begin
        in_range = r_tok.pos < DEPTH_V;
        less     = $signed(r_tok.key) < $signed(r_rd_key);
        slot_num = BASE_V + r_tok.pos;
        wr_en    = 1'b0;
        n_out    = r_tok;
        if (r_tok.valid && !r_tok.done) begin
            if (!in_range) begin
                n_out.done = 1'b1;
            end else if (!r_rd_used) begin
                n_out.done = 1'b1;
                if (r_tok.op == ibst_pkg::OP_INSERT) begin
                    wr_en        = 1'b1;
                    n_out.status = ibst_pkg::ST_INSERTED;
                    n_out.slot   = slot_num[ibst_pkg::SLOT_W-1:0];
                end
            end else if (r_tok.key == r_rd_key) begin
                n_out.done   = 1'b1;
                n_out.slot   = slot_num[ibst_pkg::SLOT_W-1:0];
                n_out.status = (r_tok.op == ibst_pkg::OP_SEARCH) ?
                               ibst_pkg::ST_FOUND : ibst_pkg::ST_DUPLICATE;
            end else begin
                n_out.pos = {r_tok.pos[ibst_pkg::POS_W-2:0], ~less};
            end
        end
    end

    assign o_tok = r_out;
endmodule

>>> hdl/implicit_array_bst_table_unit.sv
// Channel   Dir  Payload               Transaction
// i_req     in   operation, key        valid & ready
// o_rsp     out  slot_index, status    valid & ready
//
// One operation at a time; a token walks one cell per tree level, each cell first
// registering the slot read, then the compare/write result.
// After reset each cell clears its occupancy bits one slot a cycle; the widest
// level finishes last. No request is taken meanwhile.
// A result held on o_rsp blocks the next request until it is taken.
module implicit_array_bst_table_unit #(
    parameter int SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ibst_req_if.sink    i_req,
    ibst_rsp_if.source  o_rsp
);
    localparam int LEVELS = $clog2(SLOTS + 1);

    ibst_pkg::t_token chain [LEVELS+1];
    logic [LEVELS-1:0] clr_done;
    logic r_busy, r_rsp_valid;
    logic [9:0] r_rsp_slot;
    logic [2:0] r_rsp_status;
    logic accept;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_busy && (&clr_done);

    // token entering the root level
    always_comb begin
        chain[0].valid  = accept;
        chain[0].op     = i_req.operation;
        chain[0].key    = i_req.key;
        chain[0].pos    = '0;
        chain[0].done   = 1'b0;
        chain[0].status = (i_req.operation == ibst_pkg::OP_SEARCH) ?
                          ibst_pkg::ST_NOT_FOUND : ibst_pkg::ST_FULL;
        chain[0].slot   = '0;
    end

    // one cell per tree level
    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        ibst_cell #(.SLOTS(SLOTS), .LEVEL(l)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (chain[l]),
            .o_tok      (chain[l+1]),
            .o_clr_done (clr_done[l])
        );
    end

    // busy flag and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_busy <= 1'b0;
            end
            if (chain[LEVELS].valid) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
        if (chain[LEVELS].valid) begin
            r_rsp_slot   <= chain[LEVELS].slot;
            r_rsp_status <= chain[LEVELS].status;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.slot_index = r_rsp_slot;
    assign o_rsp.status     = r_rsp_status;
endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS     = 1024;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ibst_req_if req_ch ();
    ibst_rsp_if rsp_ch ();

    implicit_array_bst_table_unit #(.SLOTS(NSLOTS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #1 i_clk = ~i_clk;

    typedef struct {
        logic [9:0] slot;
        logic [2:0] status;
    } t_lookup;

    typedef struct {
        logic        op;
        logic [31:0] key;
        logic        has_exp;
        logic [9:0]  exp_slot;
        logic [2:0]  exp_status;
    } t_row;

    // tree model
    bit          tree_used[NSLOTS];
    logic [31:0] tree_key[NSLOTS];
    int          tree_count;

    t_lookup pending_results[$];
    int      error_count;
    int      idle_cycles;
    bit      stim_done;
    logic [31:0] key_pool[$];

    function automatic t_lookup walk_tree(logic op, logic [31:0] key);
        t_lookup r;
        int idx;
        idx = 0;
        r.slot = '0;
        r.status = (op == ibst_pkg::OP_SEARCH) ? ibst_pkg::ST_NOT_FOUND : ibst_pkg::ST_FULL;
        while (idx < NSLOTS) begin
            if (!tree_used[idx]) begin
                if (op == ibst_pkg::OP_INSERT) begin
                    tree_used[idx] = 1'b1;
                    tree_key[idx] = key;
                    if (tree_count < 2047) tree_count++;
                    r.slot = idx[9:0];
                    r.status = ibst_pkg::ST_INSERTED;
                end
                break;
            end
            if ($signed(key) == $signed(tree_key[idx])) begin
                r.slot = idx[9:0];
                r.status = (op == ibst_pkg::OP_SEARCH) ? ibst_pkg::ST_FOUND :
                                                         ibst_pkg::ST_DUPLICATE;
                break;
            end
            idx = ($signed(key) < $signed(tree_key[idx])) ? 2 * idx + 1 : 2 * idx + 2;
        end
        return r;
    endfunction

    // sender: bursts and gaps, changes on falling edge
    int burst_left = 0;
    int gap_left = 0;

    task automatic send_op(logic op, logic [31:0] key, bit has_exp, logic [9:0] es,
                           logic [2:0] est);
        t_lookup r;
        while (gap_left > 0) begin
            @(negedge i_clk);
            gap_left--;
        end
        req_ch.operation <= op;
        req_ch.key <= key;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        r = walk_tree(op, key);
        if (has_exp && (r.slot !== es || r.status !== est)) begin
            $display("%0t directed row prediction differs: slot %0d status %0d vs %0d %0d",
                     $time, es, est, r.slot, r.status);
            error_count++;
        end
        pending_results.push_back(r);
        if (op == ibst_pkg::OP_INSERT) key_pool.push_back(key);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
            if (gap_left > 0) req_ch.valid <= 1'b0;
        end
    endtask

    // receiver stall pattern
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[9:8] == 2'd0) rsp_ch.ready <= 1'b1;
        else if (stall_phase[9:8] == 2'd1) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        else rsp_ch.ready <= ($urandom_range(0, 4) == 0) ? 1'b0 :
                             ($urandom_range(0, 1) == 1);
    end

    // result checker
    always @(posedge i_clk) begin
        t_lookup e;
        if (rsp_ch.valid && rsp_ch.ready && i_rst_n) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected transaction: slot %0d status %0d",
                         $time, rsp_ch.slot_index, rsp_ch.status);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (rsp_ch.slot_index !== e.slot) begin
                    $display("%0t slot_index expected %0d actual %0d",
                             $time, e.slot, rsp_ch.slot_index);
                    error_count++;
                end
                if (rsp_ch.status !== e.status) begin
                    $display("%0t status expected %0d actual %0d",
                             $time, e.status, rsp_ch.status);
                    error_count++;
                end
            end
        end
    end

    // watchdog on accepted transactions
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            !i_rst_n || (stim_done && pending_results.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // directed rows; expectations typed only where obvious
    t_row rows[$];

    task automatic add_row(logic op, logic [31:0] key, bit he = 0,
                           logic [9:0] es = '0, logic [2:0] est = '0);
        t_row r;
        r.op = op; r.key = key; r.has_exp = he; r.exp_slot = es; r.exp_status = est;
        rows.push_back(r);
    endtask

    // random well-formed tree: a fresh table is not possible (no reset), so
    // mix fresh keys, repeats, and searches for known and unknown keys
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && key_pool.size() > 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (sel == 4) return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFF0}
                             + $urandom_range(0, 15);
        if (sel == 5) return $urandom_range(0, 63) - 32;
        return $urandom;
    endfunction

    initial begin
        int n;
        int settle;
        error_count = 0;
        stim_done = 0;
        tree_count = 0;
        foreach (tree_used[i]) tree_used[i] = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = ibst_pkg::OP_INSERT;
        req_ch.key = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(ibst_pkg::OP_SEARCH, 32'd0, 1, 10'd0, ibst_pkg::ST_NOT_FOUND); // empty tree
        add_row(ibst_pkg::OP_INSERT, 32'd0, 1, 10'd0, ibst_pkg::ST_INSERTED);  // root
        add_row(ibst_pkg::OP_INSERT, 32'h8000_0000, 1, 10'd1,
                ibst_pkg::ST_INSERTED);                                         // most negative
        add_row(ibst_pkg::OP_INSERT, 32'h7FFF_FFFF, 1, 10'd2,
                ibst_pkg::ST_INSERTED);                                         // most positive
        add_row(ibst_pkg::OP_INSERT, 32'd0, 1, 10'd0, ibst_pkg::ST_DUPLICATE);
        add_row(ibst_pkg::OP_SEARCH, 32'h8000_0000, 1, 10'd1, ibst_pkg::ST_FOUND);
        add_row(ibst_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1, 10'd2, ibst_pkg::ST_FOUND);
        add_row(ibst_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1, 10'd0, ibst_pkg::ST_NOT_FOUND);
        add_row(ibst_pkg::OP_INSERT, 32'hFFFF_FFFF);
        add_row(ibst_pkg::OP_INSERT, 32'd1);
        add_row(ibst_pkg::OP_INSERT, 32'h8000_0000, 1, 10'd1, ibst_pkg::ST_DUPLICATE);
        add_row(ibst_pkg::OP_SEARCH, 32'h5555_5555);
        add_row(ibst_pkg::OP_SEARCH, 32'hAAAA_AAAA);
        // ascending chain of right children runs off the array
        for (int i = 0; i < 10; i++) add_row(ibst_pkg::OP_INSERT, 32'h7FFF_FF00 + i);
        add_row(ibst_pkg::OP_INSERT, 32'h7FFF_FFFE, 1, 10'd0, ibst_pkg::ST_FULL);
        add_row(ibst_pkg::OP_SEARCH, 32'h7FFF_FFFE, 1, 10'd0, ibst_pkg::ST_NOT_FOUND);

        foreach (rows[i])
            send_op(rows[i].op, rows[i].key, rows[i].has_exp, rows[i].exp_slot,
                    rows[i].exp_status);

        n = 1850;
        for (int i = 0; i < n; i++)
            send_op(($urandom_range(0, 2) == 0) ? ibst_pkg::OP_SEARCH : ibst_pkg::OP_INSERT,
                    pick_key(), 1'b0, '0, '0);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        stim_done = 1;

        settle = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        while (settle < 60) begin
            @(posedge i_clk);
            settle++;
        end
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
